[rtl/core/quad_x_mixer_incremental_pwm_core_defines.svh]
// Assertion macros for the mixer's checker.
`ifndef QUAD_X_MIXER_INCREMENTAL_PWM_CORE_DEFINES_SVH
`define QUAD_X_MIXER_INCREMENTAL_PWM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define QXM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define QXM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed: next-cycle implication");

`endif

[rtl/core/qxm_pkg.sv]
// Shared constants, types and helpers of the X-frame motor mixer.
package qxm_pkg;

    // Frame and field sizes.
    localparam int MOTOR_COUNT = 4;
    localparam int PULSE_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRUST = 2'd2;

    // Register reset values.
    localparam logic [PULSE_W-1:0]        PULSE_MIN_RST   = 16'd1000;
    localparam logic [PULSE_W-1:0]        PULSE_MAX_RST   = 16'd2000;
    localparam logic signed [ANGLE_W-1:0] BASE_THRUST_RST = 16'sd230;

    // 0.707 in Q0.16.
    localparam logic [15:0] COEF_Q16 = 16'd46334;

    // Product of an angle and the coefficient, and the Q.24 mix.
    localparam int PROD_W = 33;
    localparam int MIX_W  = 34;

    // The divide by 256000 is a shift by 11 followed by a divide by 125.
    localparam int DIV_SHIFT = 11;
    localparam int QUO_W     = MIX_W - DIV_SHIFT;
    localparam logic signed [MIX_W-1:0] HALF_DIVISOR = 34'sd128000;

    // Bias of 32768 * 125 makes the shifted mix non-negative before the
    // reciprocal multiply, so the unsigned quotient floors correctly.
    localparam int                     UNS_W       = QUO_W;
    localparam logic signed [QUO_W:0]  DIV_BIAS    = 24'sd4096000;
    localparam int                     RECIP_W     = 24;
    localparam logic [RECIP_W-1:0]     RECIP_125   = 24'd8589935;
    localparam int                     RECIP_SHIFT = 30;
    localparam int                     RPROD_W     = UNS_W + RECIP_W;
    localparam logic signed [PULSE_W:0] QUOT_BIAS  = 17'sd32768;

    // Sign pattern per motor: a set bit negates that term for motor i.
    localparam logic [MOTOR_COUNT-1:0] NEG_PITCH = 4'b0101;
    localparam logic [MOTOR_COUNT-1:0] NEG_ROLL  = 4'b1100;
    localparam logic [MOTOR_COUNT-1:0] NEG_YAW   = 4'b1001;

    typedef logic signed [MIX_W-1:0] mix_t;

    // Applies a fixed motor sign to one mix term.
    function automatic mix_t apply_sign(input mix_t term, input logic neg);
        return neg ? -term : term;
    endfunction

endpackage

[rtl/core/quad_x_mixer_incremental_pwm_core.sv]
// Top level of the X-frame quadcopter motor mixer with pulse accumulators.

// Each input transfer carries roll, pitch and yaw corrections in Q7.8. The
// block forms four X-frame mixes, scales each by 1/1000 with round-half-up,
// adds it to that motor's Q16.16 accumulator, clamps to [pulse_min,
// pulse_max] and shows the four integer pulse parts as one result. The
// pipeline has four register stages (coefficient products, mix and shift,
// reciprocal multiply for the divide by 125, accumulate and clamp), and one
// item is taken every cycle while the result side does not stall; the
// accumulate stage, whose add depends on the previous result, sets that
// rate. Stalls on the result side back up through per-stage ready, and empty
// stages keep accepting. The accumulators reset to pulse_min in Q16.16
// (1000.0); configuration is to be written by the user only while the
// pipeline is empty, and the block itself does not enforce this.
module quad_x_mixer_incremental_pwm_core
    import qxm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ANGLE_W-1:0]   roll_angle,
    input  logic signed [ANGLE_W-1:0]   pitch_angle,
    input  logic signed [ANGLE_W-1:0]   yaw_angle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PULSE_W-1:0]          pulse_one,
    output logic [PULSE_W-1:0]          pulse_two,
    output logic [PULSE_W-1:0]          pulse_three,
    output logic [PULSE_W-1:0]          pulse_four
);

    // Configuration registers.
    logic [PULSE_W-1:0]        pulse_min_reg;
    logic [PULSE_W-1:0]        pulse_max_reg;
    logic signed [ANGLE_W-1:0] base_thrust_reg;

    // Stage valid bits and per-stage ready.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_free;

    // Stage payloads.
    logic signed [PROD_W-1:0]             roll_prod_reg, pitch_prod_reg;
    logic signed [ANGLE_W-1:0]            yaw_s1_reg;
    logic signed [PROD_W-1:0]             roll_prod, pitch_prod;
    logic [MOTOR_COUNT-1:0][UNS_W-1:0]    uns_reg, uns_next;
    logic [MOTOR_COUNT-1:0][PULSE_W-1:0]  quot_reg, quot_next;
    logic [MOTOR_COUNT-1:0][31:0]         acc_reg, acc_next;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg   <= PULSE_MIN_RST;
            pulse_max_reg   <= PULSE_MAX_RST;
            base_thrust_reg <= BASE_THRUST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_MIN:   pulse_min_reg   <= cfg_data;
                CFG_PULSE_MAX:   pulse_max_reg   <= cfg_data;
                CFG_BASE_THRUST: base_thrust_reg <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // Ready runs back from the result register through each stage.
    assign out_free = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: roll and pitch times 0.707 in Q0.16.
    assign roll_prod  = PROD_W'(roll_angle) * PROD_W'($signed({1'b0, COEF_Q16}));
    assign pitch_prod = PROD_W'(pitch_angle) * PROD_W'($signed({1'b0, COEF_Q16}));

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            roll_prod_reg  <= roll_prod;
            pitch_prod_reg <= pitch_prod;
            yaw_s1_reg     <= yaw_angle;
        end
    end

    // Stage 2: per-motor mix in Q.24, rounding offset, floor shift by 11,
    // then the bias that keeps the value non-negative.
    always_comb
    begin
        mix_t                  base_term;
        mix_t                  roll_term;
        mix_t                  pitch_term;
        mix_t                  yaw_term;
        mix_t                  mix;
        logic signed [QUO_W:0] biased;
        base_term  = $signed({{2{base_thrust_reg[ANGLE_W-1]}}, base_thrust_reg, 16'b0});
        roll_term  = $signed({roll_prod_reg[PROD_W-1], roll_prod_reg});
        pitch_term = $signed({pitch_prod_reg[PROD_W-1], pitch_prod_reg});
        yaw_term   = $signed({{2{yaw_s1_reg[ANGLE_W-1]}}, yaw_s1_reg, 16'b0});
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            mix = base_term
                + apply_sign(pitch_term, NEG_PITCH[m])
                + apply_sign(roll_term, NEG_ROLL[m])
                + apply_sign(yaw_term, NEG_YAW[m])
                + HALF_DIVISOR;
            biased = $signed({mix[MIX_W-1], mix[MIX_W-1:DIV_SHIFT]}) + DIV_BIAS;
            uns_next[m] = biased[UNS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            uns_reg <= uns_next;
        end
    end

    // Stage 3: divide by 125 through the reciprocal multiply.
    always_comb
    begin
        logic [RPROD_W-1:0] rprod;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            rprod = RPROD_W'(uns_reg[m]) * RPROD_W'(RECIP_125);
            quot_next[m] = rprod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            quot_reg <= quot_next;
        end
    end

    // Stage 4: remove the bias, accumulate and clamp; floor is tested first.
    always_comb
    begin
        logic signed [PULSE_W:0]  inc;
        logic signed [MIX_W-1:0]  sum;
        logic signed [MIX_W-1:0]  lo;
        logic signed [MIX_W-1:0]  hi;
        lo = $signed({2'b00, pulse_min_reg, 16'b0});
        hi = $signed({2'b00, pulse_max_reg, 16'b0});
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            inc = $signed({1'b0, quot_reg[m]}) - QUOT_BIAS;
            sum = $signed({2'b00, acc_reg[m]})
                + $signed({{(MIX_W-PULSE_W-1){inc[PULSE_W]}}, inc});
            if (sum < lo)
            begin
                acc_next[m] = lo[31:0];
            end
            else if (sum > hi)
            begin
                acc_next[m] = hi[31:0];
            end
            else
            begin
                acc_next[m] = sum[31:0];
            end
        end
    end

    // The accumulators double as the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                acc_reg[m] <= {PULSE_MIN_RST, 16'b0};
            end
        end
        else if (s3_valid_reg && out_free)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_one   = acc_reg[0][31:16];
    assign pulse_two   = acc_reg[1][31:16];
    assign pulse_three = acc_reg[2][31:16];
    assign pulse_four  = acc_reg[3][31:16];

endmodule

[rtl/core/qxm_checker.sv]
// Port-level checker for the motor mixer, bound to the top level.
`include "quad_x_mixer_incremental_pwm_core_defines.svh"

module qxm_checker
    import qxm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [PULSE_W-1:0]        pulse_one,
    input logic [PULSE_W-1:0]        pulse_two,
    input logic [PULSE_W-1:0]        pulse_three,
    input logic [PULSE_W-1:0]        pulse_four
);

    // A stalled result keeps its valid and its pulses.
    `QXM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pulse_one) && $stable(pulse_two) && $stable(pulse_three) && $stable(pulse_four))

    // Pulses one and four move only when the result register is free to load.
    `QXM_ASSERT_IMPLIES(a_pulse_load, !$stable(pulse_one) || !$stable(pulse_four), $past(!out_valid || out_ready))

    // With the result side free, every stage can move, so input is taken.
    `QXM_ASSERT_IMPLIES(a_in_ready, !out_valid || out_ready, in_ready)

    // An input transfer reaches the result if out_ready stays high while it moves through the stages.
    `QXM_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind quad_x_mixer_incremental_pwm_core qxm_checker u_qxm_checker (.*);

[sim/tb_quad_x_mixer_incremental_pwm_core.sv]
// Self-checking testbench for the X-frame motor mixer with pulse accumulators.
`timescale 1ns / 100ps

module tb_quad_x_mixer_incremental_pwm_core;
    import qxm_pkg::*;

    // Index that no register answers to; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } angle_set_t;

    typedef logic [MOTOR_COUNT-1:0][PULSE_W-1:0] pulse_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [ANGLE_W-1:0] roll_angle = '0;
    logic signed [ANGLE_W-1:0] pitch_angle = '0;
    logic signed [ANGLE_W-1:0] yaw_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [PULSE_W-1:0] pulse_one;
    logic [PULSE_W-1:0] pulse_two;
    logic [PULSE_W-1:0] pulse_three;
    logic [PULSE_W-1:0] pulse_four;

    // Shadow copy of the registers and the motor accumulators.
    logic [PULSE_W-1:0] shadow_min = PULSE_MIN_RST;
    logic [PULSE_W-1:0] shadow_max = PULSE_MAX_RST;
    logic signed [ANGLE_W-1:0] shadow_base = BASE_THRUST_RST;
    logic [31:0] motor_acc [MOTOR_COUNT];

    angle_set_t angle_backlog [$];
    pulse_set_t pulse_expect [$];

    bit calm = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int settings_used = 1;
    string motor_name [MOTOR_COUNT] = '{"pulse_one", "pulse_two", "pulse_three", "pulse_four"};

    quad_x_mixer_incremental_pwm_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_one   (pulse_one),
        .pulse_two   (pulse_two),
        .pulse_three (pulse_three),
        .pulse_four  (pulse_four)
    );

    // Free-running clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Quotient rounded toward minus infinity.
    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Mixes one correction set into the four accumulators and returns the pulses.
    function automatic pulse_set_t advance_pulses(input logic signed [ANGLE_W-1:0] roll,
                                                  input logic signed [ANGLE_W-1:0] pitch,
                                                  input logic signed [ANGLE_W-1:0] yaw);
        pulse_set_t res;
        longint roll_term;
        longint pitch_term;
        longint yaw_term;
        longint base_term;
        longint coef;
        longint mix;
        longint sum;
        longint lo;
        longint hi;
        coef = longint'(COEF_Q16);
        roll_term = longint'(roll);
        pitch_term = longint'(pitch);
        yaw_term = longint'(yaw);
        base_term = longint'(shadow_base);
        roll_term = roll_term * coef;
        pitch_term = pitch_term * coef;
        yaw_term = yaw_term * 65536;
        base_term = base_term * 65536;
        lo = longint'(shadow_min);
        lo = lo * 65536;
        hi = longint'(shadow_max);
        hi = hi * 65536;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            mix = base_term;
            mix = NEG_PITCH[i] ? mix - pitch_term : mix + pitch_term;
            mix = NEG_ROLL[i] ? mix - roll_term : mix + roll_term;
            mix = NEG_YAW[i] ? mix - yaw_term : mix + yaw_term;
            sum = longint'(motor_acc[i]);
            sum = sum + floor_quot(mix + 128000, 256000);
            // The floor is tested first; it wins only when the sum lies below it.
            if (sum < lo)
                sum = lo;
            else if (sum > hi)
                sum = hi;
            motor_acc[i] = sum[31:0];
            res[i] = motor_acc[i][31:16];
        end
        return res;
    endfunction

    // Draws one correction set: half full range, some small, some at the limits.
    function automatic angle_set_t random_angles();
        angle_set_t a;
        logic signed [ANGLE_W-1:0] v [3];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            if (mode < 5)
                v[k] = ANGLE_W'($urandom);
            else if (mode < 8)
                v[k] = ANGLE_W'($urandom_range(0, 1023) - 512);
            else
                case ($urandom_range(0, 4))
                    0: v[k] = 16'h8000;
                    1: v[k] = 16'h7fff;
                    2: v[k] = 16'h0000;
                    3: v[k] = 16'hffff;
                    default: v[k] = 16'h0001;
                endcase
        end
        a.roll = v[0];
        a.pitch = v[1];
        a.yaw = v[2];
        return a;
    endfunction

    // One register write; the shadow copy follows at once since the pipe is empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PULSE_MIN: shadow_min = val;
            CFG_PULSE_MAX: shadow_max = val;
            CFG_BASE_THRUST: shadow_base = val;
            default: ;
        endcase
    endtask

    // Writes a full register setting, with an optional write to the unmapped index.
    task automatic apply_setting(input logic [PULSE_W-1:0] lo_val, input logic [PULSE_W-1:0] hi_val,
                                 input logic [ANGLE_W-1:0] base_val, input bit poke_unmapped);
        write_reg(CFG_PULSE_MIN, lo_val);
        write_reg(CFG_PULSE_MAX, hi_val);
        write_reg(CFG_BASE_THRUST, base_val);
        if (poke_unmapped)
            write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Holds the sender until every pushed item is through and every result is back.
    task automatic drain_results();
        @(negedge clk);
        while (angle_backlog.size() != 0 || in_valid || pulse_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_angles(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y);
        angle_set_t a;
        a.roll = r;
        a.pitch = p;
        a.yaw = y;
        angle_backlog.push_back(a);
    endtask

    // Driver: presents backlog items, with random idle bursts between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pulse_expect.push_back(advance_pulses(roll_angle, pitch_angle, yaw_angle));
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (angle_backlog.size() != 0 && !calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (angle_backlog.size() != 0)
                begin
                    angle_set_t nxt;
                    nxt = angle_backlog.pop_front();
                    roll_angle <= nxt.roll;
                    pitch_angle <= nxt.pitch;
                    yaw_angle <= nxt.yaw;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pulse_set_t seen;
                pulse_set_t want;
                seen[0] = pulse_one;
                seen[1] = pulse_two;
                seen[2] = pulse_three;
                seen[3] = pulse_four;
                results_seen++;
                if (pulse_expect.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = pulse_expect.pop_front();
                    for (int i = 0; i < MOTOR_COUNT; i++)
                        if (seen[i] !== want[i])
                        begin
                            $error("%s: expected %0d, got %0d", motor_name[i], want[i], seen[i]);
                            mismatch_count++;
                        end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("quad_x_mixer_incremental_pwm_core test failed");
                $finish;
            end
        end
    end

    // Stimulus sequence: directed sets, then random phases over several settings.
    initial
    begin
        for (int i = 0; i < MOTOR_COUNT; i++)
            motor_acc[i] = {PULSE_MIN_RST, 16'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Field extremes under the reset setting; negative pushes sit on the floor.
        push_angles(16'h0000, 16'h0000, 16'h0000);
        push_angles(16'h7fff, 16'h7fff, 16'h7fff);
        push_angles(16'h8000, 16'h8000, 16'h8000);
        push_angles(16'h7fff, 16'h8000, 16'h0000);
        push_angles(16'h8000, 16'h7fff, 16'h0000);
        push_angles(16'h0000, 16'h0000, 16'h7fff);
        push_angles(16'h0000, 16'h0000, 16'h8000);
        push_angles(16'h7fff, 16'h0000, 16'h0000);
        push_angles(16'h8000, 16'h0000, 16'h0000);
        push_angles(16'h0000, 16'h7fff, 16'h0000);
        push_angles(16'hffff, 16'hffff, 16'hffff);
        push_angles(16'h0001, 16'h0001, 16'h0001);
        drain_results();

        // Narrow window with full thrust: one motor reaches the ceiling within a few items.
        apply_setting(16'd1000, 16'd1001, 16'h7fff, 1'b1);
        for (int k = 0; k < 8; k++)
            push_angles(16'h7fff, 16'h7fff, 16'h7fff);
        push_angles(16'h8000, 16'h8000, 16'h8000);
        push_angles(16'h0000, 16'h0000, 16'h0000);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: apply_setting(16'd0, 16'd65535, 16'h8000, 1'b1);
                1: apply_setting(16'd1500, 16'd1200, 16'h0000, 1'b0);
                2: apply_setting(16'd65535, 16'd65535, 16'h7fff, 1'b0);
                3: apply_setting(16'd0, 16'd65535, 16'h8000, 1'b0);
                4: apply_setting(16'd0, 16'd0, BASE_THRUST_RST, 1'b1);
                5: apply_setting(16'd990, 16'd1010, ANGLE_W'($urandom), 1'b0);
                RANDOM_PHASES - 1:
                begin
                    apply_setting(PULSE_MIN_RST, PULSE_MAX_RST, BASE_THRUST_RST, 1'b0);
                    calm = 1'b1;
                end
                default:
                begin
                    logic [PULSE_W-1:0] lo_pick;
                    lo_pick = PULSE_W'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        apply_setting(lo_pick, PULSE_W'(lo_pick + $urandom_range(0, 4)),
                                      ANGLE_W'($urandom), 1'b1);
                    else
                        apply_setting(lo_pick, PULSE_W'($urandom), ANGLE_W'($urandom), 1'b0);
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                angle_backlog.push_back(random_angles());
            drain_results();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pulse_expect.size() != 0)
        begin
            $error("%0d expected results never arrived", pulse_expect.size());
            mismatch_count++;
        end
        $display("Covered %0d correction sets and %0d pulse results over %0d register settings,",
                 items_sent, results_seen, settings_used);
        $display("including floor and ceiling clamping and a floor set above the ceiling.");
        if (mismatch_count == 0)
            $display("quad_x_mixer_incremental_pwm_core test passed");
        else
            $display("quad_x_mixer_incremental_pwm_core test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/qxm_pkg.sv
rtl/core/quad_x_mixer_incremental_pwm_core.sv
rtl/core/qxm_checker.sv
sim/tb_quad_x_mixer_incremental_pwm_core.sv
